### hdl/pap_pkg.sv
// Package for the polygon area / perimeter / shape block.
// Holds the sequencer state type, field widths and status codes.
// No dependencies.
package pap_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int AREA_W  = 59;
  localparam int LEN_W   = 36;
  localparam int RATIO_W = 32;
  localparam int STAT_W  = 2;
  localparam int ROOT_W  = PROD_W + 2;
  localparam int NUM_W   = 105;
  localparam int DSH_W   = AREA_W + 48;
  localparam int CNT_W   = 6;
  localparam int SQRT_STEPS = PROD_W / 2;

  localparam logic [RATIO_W-1:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [RATIO_W-1:0] RATIO_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [RATIO_W-1:0] RATIO_NEG_SAT = 32'h8000_0000;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_MUL_T,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SQRT_LD,
    ST_SQRT,
    ST_EDGE_ACC,
    ST_FIN_MAG,
    ST_SQ,
    ST_PI,
    ST_DIV_CHK,
    ST_DIV,
    ST_RATIO,
    ST_FIN
  } state_t;

endpackage

### hdl/polygon_area_perimeter_shape.sv
// Polygon area, perimeter and shape ratio, one vertex per transaction.
// The first vertex is only stored; each later vertex runs the 25x25 multiplier
// three times, then a 26-step bit-serial square root.
// The last vertex adds a closing edge, then a serial multiply and restoring
// divide on one shared wide adder (skipped for zero area) before the result is posted.
// Reset (rst_n low, synchronous): sequencer idle, sums and output valid clear.
module polygon_area_perimeter_shape (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [pap_pkg::COORD_W-1:0] in_vert_x,
  input  logic signed [pap_pkg::COORD_W-1:0] in_vert_y,
  input  logic                           in_last_vertex,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pap_pkg::AREA_W-1:0]  out_area,
  output logic        [pap_pkg::LEN_W-1:0]   out_perimeter,
  output logic signed [pap_pkg::RATIO_W-1:0] out_shape_ratio,
  output logic        [pap_pkg::STAT_W-1:0]  out_status
);

  pap_pkg::state_t state_r, state_nxt;

  // polygon state
  logic signed [pap_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                               have_first_r, last_r, closing_r;
  logic [pap_pkg::AREA_W-1:0]         area_sum_r;
  logic [pap_pkg::LEN_W-1:0]          length_sum_r;

  // edge datapath
  logic signed [pap_pkg::DIFF_W-1:0] dx_r, dy_r, sy_r;
  logic signed [pap_pkg::PROD_W-1:0] prod_r;
  logic signed [pap_pkg::DIFF_W-1:0] mul_a, mul_b;
  logic [pap_pkg::PROD_W-1:0]        rad_r;
  logic [pap_pkg::PROD_W-1:0]        rem_r;
  logic [pap_pkg::ROOT_W-1:0]        root_r;
  logic [4:0]                        k_r;
  logic [pap_pkg::ROOT_W-1:0]        sq_bit, sq_try;
  logic                              sq_ge;
  logic [pap_pkg::ROOT_W-1:0]        len_w;
  logic [pap_pkg::LEN_W:0]           len_sum_w;

  // final ratio datapath (shared wide adder)
  logic [pap_pkg::AREA_W-1:0]   mag_r;
  logic                         neg_r;
  logic [pap_pkg::NUM_W-1:0]    acc_r, mcand_r;
  logic [pap_pkg::LEN_W-1:0]    mplier_r;
  logic [pap_pkg::DSH_W-1:0]    dsh_r;
  logic [pap_pkg::RATIO_W-1:0]  q_r;
  logic                         qsat_r;
  logic [pap_pkg::CNT_W-1:0]    cnt_r;
  logic                         div_ge;
  logic [pap_pkg::AREA_W-1:0]   mag_w;
  // ratio and status wait here until the output slot frees up
  logic [pap_pkg::RATIO_W-1:0]  ratio_r;
  logic [pap_pkg::STAT_W-1:0]   stat_r;

  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // --- outputs of the sequencer
  always_comb begin
    in_ready = (state_r == pap_pkg::ST_IDLE);
  end

  // one shared signed multiplier, operands picked by state
  always_comb begin
    unique case (state_r)
      pap_pkg::ST_MUL_T: begin
        mul_a = sy_r;
        mul_b = dx_r;
      end
      pap_pkg::ST_MUL_X: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      default: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
    endcase
  end

  // square root step: try r + bit against the remainder
  assign sq_bit = pap_pkg::ROOT_W'(1) << {k_r, 1'b0};
  assign sq_try = root_r + sq_bit;
  assign sq_ge  = {2'b00, rem_r} >= sq_try;
  // round to nearest: bump when the remainder exceeds the root
  assign len_w     = root_r + pap_pkg::ROOT_W'({2'b00, rem_r} > root_r);
  assign len_sum_w = {1'b0, length_sum_r} + (pap_pkg::LEN_W+1)'(len_w);

  assign mag_w  = area_sum_r[pap_pkg::AREA_W-1] ? (~area_sum_r + 1'b1) : area_sum_r;
  assign div_ge = {2'b00, acc_r} >= dsh_r;

  // --- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pap_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!have_first_r) begin
            state_nxt = in_last_vertex ? pap_pkg::ST_CLOSE : pap_pkg::ST_IDLE;
          end else begin
            state_nxt = pap_pkg::ST_MUL_T;
          end
        end
      end
      pap_pkg::ST_CLOSE:    state_nxt = pap_pkg::ST_MUL_T;
      pap_pkg::ST_MUL_T:    state_nxt = pap_pkg::ST_MUL_X;
      pap_pkg::ST_MUL_X:    state_nxt = pap_pkg::ST_MUL_Y;
      pap_pkg::ST_MUL_Y:    state_nxt = pap_pkg::ST_SQRT_LD;
      pap_pkg::ST_SQRT_LD:  state_nxt = pap_pkg::ST_SQRT;
      pap_pkg::ST_SQRT: begin
        if (k_r == 5'd0) state_nxt = pap_pkg::ST_EDGE_ACC;
      end
      pap_pkg::ST_EDGE_ACC: begin
        priority if (closing_r) state_nxt = pap_pkg::ST_FIN_MAG;
        else if (last_r)        state_nxt = pap_pkg::ST_CLOSE;
        else                    state_nxt = pap_pkg::ST_IDLE;
      end
      pap_pkg::ST_FIN_MAG: begin
        state_nxt = (mag_w == '0) ? pap_pkg::ST_FIN : pap_pkg::ST_SQ;
      end
      pap_pkg::ST_SQ: begin
        if (cnt_r == pap_pkg::CNT_W'(pap_pkg::LEN_W - 1)) state_nxt = pap_pkg::ST_PI;
      end
      pap_pkg::ST_PI: begin
        if (cnt_r == pap_pkg::CNT_W'(pap_pkg::RATIO_W)) state_nxt = pap_pkg::ST_DIV_CHK;
      end
      pap_pkg::ST_DIV_CHK: begin
        state_nxt = ({3'b000, acc_r} >= {1'b0, mag_r, 48'd0} << 1) ?
                    pap_pkg::ST_RATIO : pap_pkg::ST_DIV;
      end
      pap_pkg::ST_DIV: begin
        if (cnt_r == pap_pkg::CNT_W'(pap_pkg::RATIO_W - 1)) state_nxt = pap_pkg::ST_RATIO;
      end
      pap_pkg::ST_RATIO:    state_nxt = pap_pkg::ST_FIN;
      pap_pkg::ST_FIN: begin
        if (!out_valid || out_ready) state_nxt = pap_pkg::ST_IDLE;
      end
      default:              state_nxt = pap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pap_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      last_r       <= 1'b0;
      closing_r    <= 1'b0;
      area_sum_r   <= '0;
      length_sum_r <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state_r == pap_pkg::ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        pap_pkg::ST_IDLE: begin
          if (in_fire) begin
            have_first_r <= 1'b1;
            last_r       <= in_last_vertex;
          end
        end
        pap_pkg::ST_CLOSE: begin
          closing_r <= 1'b1;
          last_r    <= 1'b0;
        end
        pap_pkg::ST_MUL_X: begin
          // trapezoid term, wraps modulo 2^59
          area_sum_r <= area_sum_r + pap_pkg::AREA_W'(prod_r);
        end
        pap_pkg::ST_EDGE_ACC: begin
          length_sum_r <= len_sum_w[pap_pkg::LEN_W] ? '1 : len_sum_w[pap_pkg::LEN_W-1:0];
        end
        pap_pkg::ST_FIN: begin
          if (!out_valid || out_ready) begin
            have_first_r <= 1'b0;
            closing_r    <= 1'b0;
            area_sum_r   <= '0;
            length_sum_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // --- datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      pap_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!have_first_r) begin
            first_x_r <= in_vert_x;
            first_y_r <= in_vert_y;
          end
          prev_x_r <= in_vert_x;
          prev_y_r <= in_vert_y;
          dx_r <= pap_pkg::DIFF_W'(in_vert_x) - pap_pkg::DIFF_W'(prev_x_r);
          dy_r <= pap_pkg::DIFF_W'(in_vert_y) - pap_pkg::DIFF_W'(prev_y_r);
          sy_r <= pap_pkg::DIFF_W'(in_vert_y) + pap_pkg::DIFF_W'(prev_y_r);
        end
      end
      pap_pkg::ST_CLOSE: begin
        dx_r <= pap_pkg::DIFF_W'(first_x_r) - pap_pkg::DIFF_W'(prev_x_r);
        dy_r <= pap_pkg::DIFF_W'(first_y_r) - pap_pkg::DIFF_W'(prev_y_r);
        sy_r <= pap_pkg::DIFF_W'(first_y_r) + pap_pkg::DIFF_W'(prev_y_r);
      end
      pap_pkg::ST_MUL_T, pap_pkg::ST_MUL_X: begin
        prod_r <= mul_a * mul_b;
      end
      pap_pkg::ST_MUL_Y: begin
        rad_r  <= prod_r;
        prod_r <= mul_a * mul_b;
      end
      pap_pkg::ST_SQRT_LD: begin
        rem_r  <= rad_r + prod_r;
        root_r <= '0;
        k_r    <= 5'(pap_pkg::SQRT_STEPS);
      end
      pap_pkg::ST_SQRT: begin
        if (sq_ge) begin
          rem_r  <= rem_r - pap_pkg::PROD_W'(sq_try);
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
        k_r <= k_r - 5'd1;
      end
      pap_pkg::ST_FIN_MAG: begin
        neg_r    <= area_sum_r[pap_pkg::AREA_W-1];
        mag_r    <= mag_w;
        acc_r    <= '0;
        mcand_r  <= pap_pkg::NUM_W'(length_sum_r);
        mplier_r <= length_sum_r;
        cnt_r    <= '0;
        qsat_r   <= 1'b0;
        q_r      <= '0;
      end
      pap_pkg::ST_SQ, pap_pkg::ST_PI: begin
        // serial shift-add multiply; the last SQ step lands the square in
        // mcand and loads 1/pi as the next multiplier
        if (state_r == pap_pkg::ST_SQ && cnt_r == pap_pkg::CNT_W'(pap_pkg::LEN_W - 1)) begin
          acc_r    <= '0;
          mcand_r  <= acc_r + (mplier_r[0] ? mcand_r : '0);
          mplier_r <= pap_pkg::LEN_W'(pap_pkg::INV_PI_Q32);
          cnt_r    <= '0;
        end else begin
          acc_r    <= acc_r + (mplier_r[0] ? mcand_r : '0);
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
        end
      end
      pap_pkg::ST_DIV_CHK: begin
        qsat_r <= ({3'b000, acc_r} >= {1'b0, mag_r, 48'd0} << 1);
        dsh_r  <= {mag_r, 48'd0};
        cnt_r  <= '0;
      end
      pap_pkg::ST_DIV: begin
        if (div_ge) acc_r <= acc_r - pap_pkg::NUM_W'(dsh_r);
        q_r   <= {q_r[pap_pkg::RATIO_W-2:0], div_ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      pap_pkg::ST_RATIO: begin
        if (!neg_r) begin
          if (qsat_r || q_r[pap_pkg::RATIO_W-1]) begin
            ratio_r <= pap_pkg::RATIO_POS_SAT;
            stat_r  <= pap_pkg::STAT_SAT;
          end else begin
            ratio_r <= q_r;
            stat_r  <= pap_pkg::STAT_OK;
          end
        end else begin
          if (qsat_r || (q_r[pap_pkg::RATIO_W-1] && q_r[pap_pkg::RATIO_W-2:0] != '0)) begin
            ratio_r <= pap_pkg::RATIO_NEG_SAT;
            stat_r  <= pap_pkg::STAT_SAT;
          end else begin
            ratio_r <= ~q_r + 1'b1;
            stat_r  <= pap_pkg::STAT_OK;
          end
        end
      end
      pap_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_area      <= $signed(area_sum_r) >>> 1;
          out_perimeter <= length_sum_r;
          if (mag_r == '0) begin
            out_shape_ratio <= '0;
            out_status      <= pap_pkg::STAT_ZERO;
          end else begin
            out_shape_ratio <= ratio_r;
            out_status      <= stat_r;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/pap_checker.sv
// Port-level checker for polygon_area_perimeter_shape, bound to the top level.
// Depends on pap_pkg for status codes and saturation values.
module pap_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pap_pkg::AREA_W-1:0]        out_area,
  input logic [pap_pkg::RATIO_W-1:0]       out_shape_ratio,
  input logic [pap_pkg::STAT_W-1:0]        out_status
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_area) && $stable(out_shape_ratio))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pap_pkg::STAT_ZERO |-> out_shape_ratio == '0)
    else $error("zero-area result with nonzero ratio");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pap_pkg::STAT_SAT |->
      out_shape_ratio == pap_pkg::RATIO_POS_SAT || out_shape_ratio == pap_pkg::RATIO_NEG_SAT)
    else $error("saturated status without a saturated ratio");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != pap_pkg::STAT_BAD)
    else $error("undefined status code");

endmodule

bind polygon_area_perimeter_shape pap_checker u_pap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_area        (out_area),
  .out_shape_ratio (out_shape_ratio),
  .out_status      (out_status)
);

### tb/polygon_area_perimeter_shape_tb.sv
// Testbench for polygon_area_perimeter_shape: random and directed polygons
// checked against a built-in area/perimeter/shape-ratio predictor.
// Depends on pap_pkg and the RTL top module.
`timescale 1ns / 1ps

module polygon_area_perimeter_shape_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic signed [pap_pkg::COORD_W-1:0] x;
    logic signed [pap_pkg::COORD_W-1:0] y;
    logic                               last;
  } vertex_t;

  typedef struct packed {
    logic [pap_pkg::AREA_W-1:0]  area;
    logic [pap_pkg::LEN_W-1:0]   perim;
    logic [pap_pkg::RATIO_W-1:0] ratio;
    logic [pap_pkg::STAT_W-1:0]  status;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [pap_pkg::COORD_W-1:0] in_vert_x = '0;
  logic signed [pap_pkg::COORD_W-1:0] in_vert_y = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [pap_pkg::AREA_W-1:0]  out_area;
  logic        [pap_pkg::LEN_W-1:0]   out_perimeter;
  logic signed [pap_pkg::RATIO_W-1:0] out_shape_ratio;
  logic        [pap_pkg::STAT_W-1:0]  out_status;

  always #2 clk = ~clk;

  polygon_area_perimeter_shape u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_vert_x, .in_vert_y, .in_last_vertex,
    .out_valid, .out_ready, .out_area, .out_perimeter, .out_shape_ratio, .out_status
  );

  vertex_t      vertex_queue[$];
  poly_result_t expected_polys[$];
  int  mismatch_count = 0;
  bit  stim_done = 1'b0;
  bit  hold_rx = 1'b1;
  int  idle_cycles = 0;

  // predictor state
  logic signed [pap_pkg::COORD_W-1:0] p_first_x, p_first_y, p_prev_x, p_prev_y;
  logic [pap_pkg::AREA_W-1:0] p_area2 = '0;
  logic [pap_pkg::LEN_W-1:0]  p_len = '0;
  bit p_have_first = 1'b0;

  // bit-serial integer sqrt, rounded to nearest
  function automatic longint unsigned edge_root(longint unsigned s);
    longint unsigned r, b, rem;
    r = 0; b = 64'd1 << 50; rem = s;
    while (b > rem && b != 0) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r++;
    return r;
  endfunction

  function automatic void accumulate_edge(logic signed [pap_pkg::COORD_W-1:0] x1, y1, x2, y2);
    longint signed dx, dy, term;
    longint unsigned ax, ay, sum;
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    term = (longint'(y1) + longint'(y2)) * dx;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    p_area2 = p_area2 + term[pap_pkg::AREA_W-1:0];
    sum = longint'(p_len) + edge_root(ax * ax + ay * ay);
    p_len = (sum > 64'hF_FFFF_FFFF) ? '1 : sum[pap_pkg::LEN_W-1:0];
  endfunction

  // returns 1 when the vertex closes a polygon
  function automatic bit predict_vertex(vertex_t v, output poly_result_t res);
    logic [pap_pkg::AREA_W-1:0] mag;
    logic [127:0] num, den;
    logic [32:0] q;
    bit neg;
    if (!p_have_first) begin
      p_first_x = v.x; p_first_y = v.y; p_have_first = 1'b1;
    end else begin
      accumulate_edge(p_prev_x, p_prev_y, v.x, v.y);
    end
    p_prev_x = v.x; p_prev_y = v.y;
    if (!v.last) return 1'b0;
    accumulate_edge(v.x, v.y, p_first_x, p_first_y);
    neg = p_area2[pap_pkg::AREA_W-1];
    mag = neg ? -p_area2 : p_area2;
    res.ratio = '0;
    res.status = pap_pkg::STAT_OK;
    if (mag == 0) begin
      res.status = pap_pkg::STAT_ZERO;
    end else begin
      num = 128'(p_len) * 128'(p_len) * 128'(pap_pkg::INV_PI_Q32);
      den = 128'(mag) << 17;
      q = (num >= (den << 32)) ? 33'h1_0000_0000 : 33'(num / den);
      if (!neg) begin
        if (q > 33'h7FFF_FFFF) begin
          res.ratio = pap_pkg::RATIO_POS_SAT; res.status = pap_pkg::STAT_SAT;
        end else res.ratio = q[31:0];
      end else begin
        if (q > 33'h8000_0000) begin
          res.ratio = pap_pkg::RATIO_NEG_SAT; res.status = pap_pkg::STAT_SAT;
        end else res.ratio = -q[31:0];
      end
    end
    res.area = {p_area2[pap_pkg::AREA_W-1], p_area2[pap_pkg::AREA_W-1:1]};
    res.perim = p_len;
    p_area2 = '0; p_len = '0; p_have_first = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [pap_pkg::COORD_W-1:0] rand_coord(int mode);
    unique case (mode)
      0: return pap_pkg::COORD_W'($urandom);
      1: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  task automatic add_vertex(logic signed [pap_pkg::COORD_W-1:0] x, y, bit last);
    vertex_t v;
    v.x = x; v.y = y; v.last = last;
    vertex_queue.push_back(v);
  endtask

  // Stimulus: directed corners, then random polygons
  initial begin
    int n, mode;
    add_vertex(24'sd100, -24'sd7, 1'b1);                         // single vertex
    add_vertex(24'sd0, 24'sd0, 1'b0); add_vertex(24'sd256, 24'sd0, 1'b0); // unit triangle
    add_vertex(24'sd0, 24'sd256, 1'b1);
    add_vertex(24'sd0, 24'sd0, 1'b0); add_vertex(24'sd0, 24'sd256, 1'b0); // cw, positive
    add_vertex(24'sd256, 24'sd0, 1'b1);
    add_vertex(24'sd0, 24'sd0, 1'b0); add_vertex(24'sd512, 24'sd512, 1'b1); // degenerate
    add_vertex(24'sh800000, 24'sh800000, 1'b0);                  // full-range square
    add_vertex(24'sh7FFFFF, 24'sh800000, 1'b0);
    add_vertex(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    add_vertex(24'sh800000, 24'sh7FFFFF, 1'b1);
    add_vertex(24'sd0, 24'sd0, 1'b0); add_vertex(24'sh7FFFFF, 24'sd0, 1'b0); // sliver
    add_vertex(24'sh7FFFFF, 24'sd1, 1'b1);
    add_vertex(24'sd0, 24'sd0, 1'b0); add_vertex(24'sh7FFFFF, 24'sd1, 1'b0);
    add_vertex(24'sh7FFFFF, 24'sd0, 1'b1);
    add_vertex(24'sh800000, 24'sh7FFFFF, 1'b0); add_vertex(24'sh7FFFFF, 24'sh800000, 1'b0);
    add_vertex(24'sh800000, 24'sh800000, 1'b1);
    n = 0;
    while (n < 380) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      mode = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        add_vertex(rand_coord(mode < 3 ? 1 : (mode < 5 ? 0 : 2)),
                   rand_coord(mode < 3 ? 1 : (mode < 5 ? 0 : 2)), i == len - 1);
        n++;
      end
    end
  end

  // Reset, then sender burst/gap driver
  int burst_left = 0, gap_left = 0, rst_count = 0;
  always @(posedge clk) begin
    poly_result_t r;
    if (rst_count < 7) begin
      rst_count <= rst_count + 1;
      rst_n <= (rst_count == 6);
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) begin
        if (predict_vertex(vertex_queue[0], r)) expected_polys.push_back(r);
        void'(vertex_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (vertex_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_vert_x <= vertex_queue[0].x;
        in_vert_y <= vertex_queue[0].y;
        in_last_vertex <= vertex_queue[0].last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= $urandom_range(0, 1) ? $urandom_range(0, 40) : 0;
        end else burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Receiver: long hold-off early in the run, then its own stall pattern
  int rx_phase = 0;
  initial begin
    repeat (3000) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_rx) out_ready <= 1'b0;
    else if (rx_phase[9]) out_ready <= 1'b1;
    else out_ready <= (rx_phase % 7 < 3) || ($urandom_range(0, 3) == 0);
  end

  // Result monitor
  always @(posedge clk) begin
    poly_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_polys.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction");
      end else begin
        e = expected_polys.pop_front();
        if (out_area !== e.area || out_perimeter !== e.perim ||
            out_shape_ratio !== e.ratio || out_status !== e.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp area %h perim %h ratio %h st %0d, got %h %h %h %0d",
                     e.area, e.perim, e.ratio, e.status,
                     out_area, out_perimeter, out_shape_ratio, out_status);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** polygon_area_perimeter_shape: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_polys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("** polygon_area_perimeter_shape: PASSED **");
    else $display("** polygon_area_perimeter_shape: FAILED **");
    $finish;
  end

endmodule
